FILE: design/demand_paged_address_translator_assert.svh
// assertion macros for the demand paged address translator checker
// expects clk and rst_n in the scope of each use
`ifndef DEMAND_PAGED_ADDRESS_TRANSLATOR_ASSERT_SVH
`define DEMAND_PAGED_ADDRESS_TRANSLATOR_ASSERT_SVH

// condition holds in the same cycle
`define DPAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define DPAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dpat_pkg.sv
// shared types and constants of the demand paged address translator
// no dependencies
`timescale 1ns / 1ps

package dpat_pkg;

  localparam int ADDR_W         = 32;
  localparam int SPACE_ID_W     = 4;
  localparam int PAGE_BITS_DEF  = 12;
  localparam int MAX_PAGES_DEF  = 1024;
  localparam int SPACE_BITS_DEF = 4;

  localparam logic KIND_FWD = 1'b0;
  localparam logic KIND_REV = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REV_RD,
    ST_REV_DATA,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic req_load;
    logic scan_issue;
    logic rev_issue;
    logic fwd_hit;
    logic fwd_miss;
    logic rev_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic issue_ok;
    logic cmp_valid;
    logic cmp_match;
    logic out_free;
  } sts_t;

endpackage

FILE: design/dpat_intf.sv
// request and result channel interfaces of the address translator
// depends on dpat_pkg
`timescale 1ns / 1ps

interface dpat_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [dpat_pkg::SPACE_ID_W-1:0] space_id;
  logic [dpat_pkg::ADDR_W-1:0]     address;

  modport source (output valid, kind, space_id, address, input ready);
  modport sink (input valid, kind, space_id, address, output ready);
endinterface

interface dpat_out_if;
  logic                           valid;
  logic                           ready;
  logic [dpat_pkg::ADDR_W-1:0]     result_address;
  logic                           hit;
  logic                           allocated;
  logic                           table_full;
  logic [dpat_pkg::SPACE_ID_W-1:0] space_out;

  modport source (output valid, result_address, hit, allocated, table_full, space_out,
                  input ready);
  modport sink (input valid, result_address, hit, allocated, table_full, space_out,
                output ready);
endinterface

FILE: design/demand_paged_address_translator.sv
// Demand paged address translator. Requests arrive as words on in_ch, one
// result word per request leaves on out_ch; both use valid/ready.
// A forward request (kind 0) scans the page table from entry 0 upward, one
// entry per cycle through the table ram read port, and returns the physical
// address on a hit; on a miss it claims the next free physical page, or
// flags table_full once every page is in use. A reverse request (kind 1)
// reads the entry of the given physical page in a single ram access.
// One request is in work at a time; the next is taken in the cycle after the
// result loads; the scan sets the rate. The finished result sits in an output
// register, so the next request is accepted while a stalled result waits;
// that request then holds in its last step until the output register frees up.
// Reset empties the table (page count to zero) and holds in_ready low; no
// clearing pass is needed.
// depends on dpat_pkg, dpat_intf, dpat_ctrl and dpat_dpath
`timescale 1ns / 1ps

module demand_paged_address_translator #(
  parameter int PAGE_BITS  = dpat_pkg::PAGE_BITS_DEF,
  parameter int MAX_PAGES  = dpat_pkg::MAX_PAGES_DEF,
  parameter int SPACE_BITS = dpat_pkg::SPACE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dpat_in_if.sink     in_ch,
  dpat_out_if.source  out_ch
);

  dpat_pkg::cmd_t cmd;
  dpat_pkg::sts_t sts;

  dpat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dpat_dpath #(
    .PAGE_BITS  (PAGE_BITS),
    .MAX_PAGES  (MAX_PAGES),
    .SPACE_BITS (SPACE_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_space_id        (in_ch.space_id),
    .in_address         (in_ch.address),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_result_address (out_ch.result_address),
    .out_hit            (out_ch.hit),
    .out_allocated      (out_ch.allocated),
    .out_table_full     (out_ch.table_full),
    .out_space_out      (out_ch.space_out)
  );

endmodule

FILE: design/dpat_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module dpat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/dpat_ctrl.sv
// control state machine of the address translator
// depends on dpat_pkg; drives commands into dpat_dpath
`timescale 1ns / 1ps

module dpat_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_kind,
  output logic           in_ready,
  input  dpat_pkg::sts_t sts,
  output dpat_pkg::cmd_t cmd
);

  dpat_pkg::state_t state_r;
  dpat_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dpat_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dpat_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_kind == dpat_pkg::KIND_REV) ? dpat_pkg::ST_REV_RD
                                                      : dpat_pkg::ST_SCAN;
        end
      end
      dpat_pkg::ST_SCAN: begin
        if (sts.cmp_valid && sts.cmp_match) begin
          state_nxt = dpat_pkg::ST_DONE;
        end else if (!sts.issue_ok && !sts.cmp_valid) begin
          state_nxt = dpat_pkg::ST_DONE;
        end
      end
      dpat_pkg::ST_REV_RD:   state_nxt = dpat_pkg::ST_REV_DATA;
      dpat_pkg::ST_REV_DATA: state_nxt = dpat_pkg::ST_DONE;
      dpat_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = dpat_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dpat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      dpat_pkg::ST_IDLE: begin
        in_ready     = rst_n;
        cmd.req_load = in_valid && rst_n;
      end
      dpat_pkg::ST_SCAN: begin
        if (sts.cmp_valid && sts.cmp_match) begin
          cmd.fwd_hit = 1'b1;
        end else if (!sts.issue_ok && !sts.cmp_valid) begin
          cmd.fwd_miss = 1'b1;
        end else begin
          cmd.scan_issue = sts.issue_ok;
        end
      end
      dpat_pkg::ST_REV_RD:   cmd.rev_issue = 1'b1;
      dpat_pkg::ST_REV_DATA: cmd.rev_load = 1'b1;
      dpat_pkg::ST_DONE:     cmd.out_load = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: design/dpat_dpath.sv
// datapath of the address translator: page table ram, scan pointer,
// compare stage, page count, result and output registers
// depends on dpat_pkg and dpat_ram; commanded by dpat_ctrl
`timescale 1ns / 1ps

module dpat_dpath #(
  parameter int PAGE_BITS  = dpat_pkg::PAGE_BITS_DEF,
  parameter int MAX_PAGES  = dpat_pkg::MAX_PAGES_DEF,
  parameter int SPACE_BITS = dpat_pkg::SPACE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dpat_pkg::cmd_t                  cmd,
  output dpat_pkg::sts_t                  sts,
  input  logic [dpat_pkg::SPACE_ID_W-1:0] in_space_id,
  input  logic [dpat_pkg::ADDR_W-1:0]     in_address,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [dpat_pkg::ADDR_W-1:0]     out_result_address,
  output logic                            out_hit,
  output logic                            out_allocated,
  output logic                            out_table_full,
  output logic [dpat_pkg::SPACE_ID_W-1:0] out_space_out
);

  localparam int VPN_W = dpat_pkg::ADDR_W - PAGE_BITS;
  localparam int CAP   = (MAX_PAGES < (2 ** VPN_W)) ? MAX_PAGES : (2 ** VPN_W);
  localparam int IDX_W = $clog2(CAP);
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int ENT_W = SPACE_BITS + VPN_W;

  logic [SPACE_BITS-1:0] req_space_r;
  logic [VPN_W-1:0]      req_page_r;
  logic [PAGE_BITS-1:0]  req_off_r;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             cmp_valid_r;

  logic [dpat_pkg::ADDR_W-1:0]     res_addr_r;
  logic                            res_hit_r;
  logic                            res_alloc_r;
  logic                            res_full_r;
  logic [dpat_pkg::SPACE_ID_W-1:0] res_space_r;

  logic [dpat_pkg::ADDR_W-1:0]     out_addr_r;
  logic                            out_hit_r;
  logic                            out_alloc_r;
  logic                            out_full_r;
  logic [dpat_pkg::SPACE_ID_W-1:0] out_space_r;
  logic                            out_valid_r;

  logic                  ram_we;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ENT_W-1:0]      ram_rdata;
  logic [SPACE_BITS-1:0] ent_space;
  logic [VPN_W-1:0]      ent_page;
  logic                  tbl_full;
  logic                  rev_in_range;

  assign tbl_full     = (count_r == CNT_W'(CAP));
  assign ram_we       = cmd.fwd_miss && !tbl_full;
  assign ram_re       = cmd.scan_issue || cmd.rev_issue;
  assign ram_raddr    = cmd.scan_issue ? rd_idx_r[IDX_W-1:0] : req_page_r[IDX_W-1:0];
  assign ent_space    = ram_rdata[ENT_W-1 -: SPACE_BITS];
  assign ent_page     = ram_rdata[VPN_W-1:0];
  assign rev_in_range = (dpat_pkg::ADDR_W'(req_page_r) < dpat_pkg::ADDR_W'(count_r));

  dpat_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAP)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata ({req_space_r, req_page_r}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.issue_ok  = (rd_idx_r < count_r);
    sts.cmp_valid = cmp_valid_r;
    sts.cmp_match = (ent_space == req_space_r) && (ent_page == req_page_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_space_r <= SPACE_BITS'(in_space_id);
      req_page_r  <= in_address[dpat_pkg::ADDR_W-1:PAGE_BITS];
      req_off_r   <= in_address[PAGE_BITS-1:0];
    end
  end

  // scan pointer, compare stage and page count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_idx_r    <= '0;
      cmp_valid_r <= 1'b0;
    end else begin
      cmp_valid_r <= cmd.scan_issue;
      if (cmd.req_load) begin
        rd_idx_r <= '0;
      end else if (cmd.scan_issue) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
      if (ram_we) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      cmp_idx_r <= rd_idx_r[IDX_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.fwd_hit) begin
      res_addr_r  <= {VPN_W'(cmp_idx_r), req_off_r};
      res_hit_r   <= 1'b1;
      res_alloc_r <= 1'b0;
      res_full_r  <= 1'b0;
      res_space_r <= '0;
    end else if (cmd.fwd_miss) begin
      res_addr_r  <= tbl_full ? '0 : {VPN_W'(count_r), req_off_r};
      res_hit_r   <= 1'b0;
      res_alloc_r <= !tbl_full;
      res_full_r  <= tbl_full;
      res_space_r <= '0;
    end else if (cmd.rev_load) begin
      res_addr_r  <= rev_in_range ? {ent_page, req_off_r} : '0;
      res_hit_r   <= rev_in_range;
      res_alloc_r <= 1'b0;
      res_full_r  <= 1'b0;
      res_space_r <= rev_in_range ? dpat_pkg::SPACE_ID_W'(ent_space) : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_addr_r  <= res_addr_r;
      out_hit_r   <= res_hit_r;
      out_alloc_r <= res_alloc_r;
      out_full_r  <= res_full_r;
      out_space_r <= res_space_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_hit            = out_hit_r;
  assign out_allocated      = out_alloc_r;
  assign out_table_full     = out_full_r;
  assign out_space_out      = out_space_r;

endmodule

FILE: design/dpat_checker.sv
// port level checks of the address translator and their bind
// depends on dpat_pkg and demand_paged_address_translator_assert.svh
`timescale 1ns / 1ps
`include "demand_paged_address_translator_assert.svh"

module dpat_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [dpat_pkg::ADDR_W-1:0]     out_result_address,
  input logic                            out_hit,
  input logic                            out_allocated,
  input logic                            out_table_full,
  input logic [dpat_pkg::SPACE_ID_W-1:0] out_space_out
);

  `DPAT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `DPAT_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready, "second word taken in work")
  `DPAT_ASSERT_NOW(a_flags_excl, out_valid, $countones({out_hit, out_allocated, out_table_full}) <= 1, "conflicting result flags")
  `DPAT_ASSERT_NOW(a_full_zero, out_valid && out_table_full, (out_result_address == '0) && (out_space_out == '0), "full result not zero")
  `DPAT_ASSERT_NOW(a_alloc_space, out_valid && out_allocated, out_space_out == '0, "space set on allocation")

endmodule

bind demand_paged_address_translator dpat_checker u_dpat_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_result_address (out_ch.result_address),
  .out_hit            (out_ch.hit),
  .out_allocated      (out_ch.allocated),
  .out_table_full     (out_ch.table_full),
  .out_space_out      (out_ch.space_out)
);
